// ----- src/assert_macros.svh -----
// Assertion macros for the escape-time core modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every clock edge outside reset
`define MET_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// antecedent in this cycle implies consequent in the same cycle
`define MET_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent in this cycle implies consequent in the next cycle
`define MET_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/met_pkg.sv -----
// Shared types and constants for the escape-time core
package met_pkg;

  localparam int COORD_WIDTH_DEF = 64;
  localparam int FRAC_BITS_DEF   = 56;
  localparam int SIDE_MAX_DEF    = 4096;

  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 3;
  localparam int STEP_W    = 63;
  localparam int ITER_W    = 32;
  localparam int CUT_W     = 7;
  localparam int IDX_W     = 12;
  localparam int LIMB_W    = 32;

  localparam logic [CFG_W-1:0]  ORIGIN_RST   = 64'hFE00_0000_0000_0000;
  localparam logic [STEP_W-1:0] STEP_RST     = 63'h0001_0000_0000_0000;
  localparam logic [ITER_W-1:0] MAX_ITER_RST = 32'd256;
  localparam logic [CUT_W-1:0]  CUTOFF_RST   = 7'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_STEP     = 3'd2,
    REG_MAX_ITER = 3'd3,
    REG_CUTOFF   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0]  origin_x;
    logic [CFG_W-1:0]  origin_y;
    logic [STEP_W-1:0] step;
    logic [ITER_W-1:0] max_iter;
    logic [CUT_W-1:0]  cutoff_squared;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic cprod;
    logic csum;
    logic prep;
    logic mul;
    logic eval;
    logic upd;
    logic set_esc;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic mul_last;
    logic mesc;
    logic at_max;
    logic sat;
  } sts_t;

endpackage

// ----- src/met_regs.sv -----
// Configuration register file of the escape-time core
module met_regs import met_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output cfg_t                 cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_ORIGIN_X: cfg_nxt.origin_x       = cfg_data;
        REG_ORIGIN_Y: cfg_nxt.origin_y       = cfg_data;
        REG_STEP:     cfg_nxt.step           = cfg_data[STEP_W-1:0];
        REG_MAX_ITER: cfg_nxt.max_iter       = cfg_data[ITER_W-1:0];
        REG_CUTOFF:   cfg_nxt.cutoff_squared = cfg_data[CUT_W-1:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x       <= ORIGIN_RST;
      cfg_r.origin_y       <= ORIGIN_RST;
      cfg_r.step           <= STEP_RST;
      cfg_r.max_iter       <= MAX_ITER_RST;
      cfg_r.cutoff_squared <= CUTOFF_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ----- src/met_ctrl.sv -----
// Sequencing state machine of the escape-time core
`include "assert_macros.svh"

module met_ctrl import met_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_CPROD = 9'b000000010,
    ST_CSUM  = 9'b000000100,
    ST_PREP  = 9'b000001000,
    ST_MUL   = 9'b000010000,
    ST_DRAIN = 9'b000100000,
    ST_EVAL  = 9'b001000000,
    ST_UPD   = 9'b010000000,
    ST_FIN   = 9'b100000000
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = ST_CPROD;
        end
      end
      ST_CPROD: begin
        cmd.cprod = 1'b1;
        state_nxt = ST_CSUM;
      end
      ST_CSUM: begin
        cmd.csum  = 1'b1;
        state_nxt = ST_PREP;
      end
      ST_PREP: begin
        if (sts.sat) begin
          cmd.set_esc = 1'b1;
          state_nxt   = ST_FIN;
        end else begin
          cmd.prep  = 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        if (sts.mul_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        priority if (sts.mesc) begin
          cmd.set_esc = 1'b1;
          state_nxt   = ST_FIN;
        end else if (sts.at_max) begin
          state_nxt = ST_FIN;
        end else begin
          cmd.upd   = 1'b1;
          state_nxt = ST_PREP;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `MET_ASSERT(a_rise_from_fin, $rose(out_valid_r) |-> $past(state_r == ST_FIN), "result without finish")
  `MET_ASSERT_NEXT(a_accept_starts, in_valid && !in_stall, state_r == ST_CPROD, "accept did not start work")
  `MET_ASSERT_NEXT(a_load_shows, cmd.out_load, out_valid_r && state_r == ST_IDLE, "result load lost")
  `MET_ASSERT_NOW(a_drain_after_mul, state_r == ST_DRAIN, $past(state_r == ST_MUL), "drain out of order")

endmodule

// ----- src/met_dp.sv -----
// Fixed-point datapath of the escape-time core
module met_dp import met_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int SIDE_MAX    = SIDE_MAX_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [IDX_W-1:0]  in_row,
  input  logic [IDX_W-1:0]  in_col,
  input  cfg_t              cfg,
  input  cmd_t              cmd,
  output sts_t              sts,
  output logic [IDX_W-1:0]  out_row,
  output logic [IDX_W-1:0]  out_col,
  output logic [ITER_W-1:0] out_iteration_count,
  output logic              out_escaped
);

  localparam int CW       = COORD_WIDTH;
  localparam int NLIMB    = (CW + LIMB_W - 1) / LIMB_W;
  localparam int MAG_W    = NLIMB * LIMB_W;
  localparam int PW       = 2 * MAG_W;
  localparam int LIMB_IW  = (NLIMB > 1) ? $clog2(NLIMB) : 1;
  localparam int SH_W     = LIMB_IW + 1;
  localparam int D_W      = PW + 2;
  localparam int THR_W    = 2 * FRAC_BITS + CUT_W;
  localparam int M_W      = (PW + 1 > THR_W) ? PW + 1 : THR_W;
  localparam int PROD_W   = IDX_W + STEP_W;
  localparam int SUM_W    = PROD_W + 2;
  localparam int PP_W     = 2 * LIMB_W;

  localparam logic signed [CW-1:0]  CMAX   = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0]  CMIN   = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [D_W-1:0] HALF_X = {{(D_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
  localparam logic signed [D_W-1:0] HALF_Y = {{(D_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 2);
  localparam logic [LIMB_IW-1:0]    LIMB_LAST = LIMB_IW'(NLIMB - 1);

  logic [IDX_W-1:0]        row_r, col_r;
  logic [IDX_W-1:0]        rowc, colc;
  logic [PROD_W-1:0]       prodx, prody, prodx_r, prody_r;
  logic signed [SUM_W-1:0] sumx, sumy;
  logic signed [CW-1:0]    cx_nxt, cy_nxt, cx_r, cy_r;
  logic signed [CW-1:0]    zx_r, zy_r, zx_neg, zy_neg;
  logic [MAG_W-1:0]        magx_r, magy_r;
  logic                    negxy_r;
  logic [LIMB_IW-1:0]      ia_r, ib_r;
  logic [SH_W-1:0]         sh_r;
  logic [LIMB_W-1:0]       xa, xb, ya, yb;
  logic [PP_W-1:0]         pxx, pyy, pxy;
  logic [PP_W-1:0]         ppxx_r, ppyy_r, ppxy_r;
  logic                    ppv_r;
  logic [PW-1:0]           xx_r, yy_r, xy_r;
  logic signed [D_W-1:0]   dx, dy, nxp_r, nyp_r;
  logic signed [D_W-1:0]   nxs, nys;
  logic [M_W-1:0]          thr, msq;
  logic                    mesc_r;
  logic                    fitx, fity, fitcx, fitcy;
  logic signed [CW-1:0]    zx_nxt, zy_nxt;
  logic [ITER_W-1:0]       iter_r;
  logic                    sat_r, esc_r;
  logic [IDX_W-1:0]        out_row_r, out_col_r;
  logic [ITER_W-1:0]       out_cnt_r;
  logic                    out_esc_r;

  // pixel coordinate
  assign rowc = (32'(row_r) > 32'(SIDE_MAX - 1)) ? IDX_W'(SIDE_MAX - 1) : row_r;
  assign colc = (32'(col_r) > 32'(SIDE_MAX - 1)) ? IDX_W'(SIDE_MAX - 1) : col_r;
  assign prodx = colc * cfg.step;
  assign prody = rowc * cfg.step;

  assign sumx = $signed({{(SUM_W-CFG_W){cfg.origin_x[CFG_W-1]}}, cfg.origin_x})
              + $signed({2'b00, prodx_r});
  assign sumy = $signed({{(SUM_W-CFG_W){cfg.origin_y[CFG_W-1]}}, cfg.origin_y})
              + $signed({2'b00, prody_r});
  assign fitcx  = (sumx[SUM_W-1:CW-1] == {(SUM_W-CW+1){sumx[SUM_W-1]}});
  assign fitcy  = (sumy[SUM_W-1:CW-1] == {(SUM_W-CW+1){sumy[SUM_W-1]}});
  assign cx_nxt = fitcx ? sumx[CW-1:0] : (sumx[SUM_W-1] ? CMIN : CMAX);
  assign cy_nxt = fitcy ? sumy[CW-1:0] : (sumy[SUM_W-1] ? CMIN : CMAX);

  // limb products
  assign zx_neg = -zx_r;
  assign zy_neg = -zy_r;
  assign xa  = magx_r[ia_r*LIMB_W +: LIMB_W];
  assign xb  = magx_r[ib_r*LIMB_W +: LIMB_W];
  assign ya  = magy_r[ia_r*LIMB_W +: LIMB_W];
  assign yb  = magy_r[ib_r*LIMB_W +: LIMB_W];
  assign pxx = xa * xb;
  assign pyy = ya * yb;
  assign pxy = xa * yb;

  // rounding and escape test
  assign dx  = $signed({2'b00, xx_r}) - $signed({2'b00, yy_r}) + HALF_X;
  assign dy  = negxy_r ? (HALF_Y - $signed({2'b00, xy_r}))
                       : ($signed({2'b00, xy_r}) + HALF_Y);
  assign thr = M_W'(cfg.cutoff_squared) << (2 * FRAC_BITS);
  assign msq = M_W'(xx_r) + M_W'(yy_r);

  // z update with saturation
  assign nxs    = nxp_r + D_W'(cx_r);
  assign nys    = nyp_r + D_W'(cy_r);
  assign fitx   = (nxs[D_W-1:CW-1] == {(D_W-CW+1){nxs[D_W-1]}});
  assign fity   = (nys[D_W-1:CW-1] == {(D_W-CW+1){nys[D_W-1]}});
  assign zx_nxt = fitx ? nxs[CW-1:0] : (nxs[D_W-1] ? CMIN : CMAX);
  assign zy_nxt = fity ? nys[CW-1:0] : (nys[D_W-1] ? CMIN : CMAX);

  assign sts.mul_last = (ia_r == LIMB_LAST) && (ib_r == LIMB_LAST);
  assign sts.mesc     = mesc_r;
  assign sts.at_max   = (iter_r == cfg.max_iter);
  assign sts.sat      = sat_r;

  assign out_row             = out_row_r;
  assign out_col             = out_col_r;
  assign out_iteration_count = out_cnt_r;
  assign out_escaped         = out_esc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ppv_r <= 1'b0;
      ia_r  <= '0;
      ib_r  <= '0;
      sat_r <= 1'b0;
      esc_r <= 1'b0;
    end else begin
      ppv_r <= cmd.mul;
      if (cmd.prep) begin
        ia_r <= '0;
        ib_r <= '0;
      end else if (cmd.mul) begin
        if (ib_r == LIMB_LAST) begin
          ib_r <= '0;
          ia_r <= ia_r + 1'b1;
        end else begin
          ib_r <= ib_r + 1'b1;
        end
      end
      if (cmd.csum) begin
        sat_r <= 1'b0;
        esc_r <= 1'b0;
      end else begin
        if (cmd.upd) begin
          sat_r <= !fitx || !fity;
        end
        if (cmd.set_esc) begin
          esc_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      row_r <= in_row;
      col_r <= in_col;
    end
    if (cmd.cprod) begin
      prodx_r <= prodx;
      prody_r <= prody;
    end
    if (cmd.csum) begin
      cx_r   <= cx_nxt;
      cy_r   <= cy_nxt;
      zx_r   <= '0;
      zy_r   <= '0;
      iter_r <= '0;
    end else if (cmd.upd) begin
      zx_r   <= zx_nxt;
      zy_r   <= zy_nxt;
      iter_r <= iter_r + 1'b1;
    end
    if (cmd.prep) begin
      magx_r  <= MAG_W'($unsigned(zx_r[CW-1] ? zx_neg : zx_r));
      magy_r  <= MAG_W'($unsigned(zy_r[CW-1] ? zy_neg : zy_r));
      negxy_r <= zx_r[CW-1] ^ zy_r[CW-1];
      xx_r    <= '0;
      yy_r    <= '0;
      xy_r    <= '0;
    end else if (ppv_r) begin
      xx_r <= xx_r + (PW'(ppxx_r) << (sh_r * LIMB_W));
      yy_r <= yy_r + (PW'(ppyy_r) << (sh_r * LIMB_W));
      xy_r <= xy_r + (PW'(ppxy_r) << (sh_r * LIMB_W));
    end
    if (cmd.mul) begin
      ppxx_r <= pxx;
      ppyy_r <= pyy;
      ppxy_r <= pxy;
      sh_r   <= SH_W'(ia_r) + SH_W'(ib_r);
    end
    if (cmd.eval) begin
      nxp_r  <= dx >>> FRAC_BITS;
      nyp_r  <= dy >>> (FRAC_BITS - 1);
      mesc_r <= (thr < msq);
    end
    if (cmd.out_load) begin
      out_row_r <= row_r;
      out_col_r <= col_r;
      out_cnt_r <= iter_r;
      out_esc_r <= esc_r;
    end
  end

endmodule

// ----- src/mandelbrot_escape_time_core.sv -----
// Escape-time core: per-pixel iteration of z = z^2 + c in signed fixed point
//
// Input channel (in_valid / in_stall) takes one pixel index (in_row, in_col).
// The pixel maps to c = origin + index * step; the core iterates z = z^2 + c
// from zero until |z|^2 exceeds cutoff_squared, a z component saturates, or
// max_iter iterations are done, then returns the index, the iteration count
// and the escaped flag on the result channel (out_valid / out_stall).
// One pixel is processed at a time; in_stall is high while it is at work.
// c is built in the CPROD and CSUM states; each pass then runs PREP, MUL,
// DRAIN, EVAL and UPD, with one 32x32 multiplier each for x*x, y*y and x*y
// stepping through four limb products in MUL; a saturated z component ends
// the pixel at PREP. A result waiting in the output register does not block
// the next pixel from being accepted. When the receiver stalls, the result
// holds and a second finished pixel waits in the core until the output
// register is free. Registers are written over cfg_valid / cfg_ready /
// cfg_index / cfg_data; the user must write them only while idle, which the
// block itself does not enforce; cfg_ready is always high. Synchronous reset
// (rst_n low) returns the registers to their defaults and drops any pixel in
// flight.
module mandelbrot_escape_time_core import met_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int SIDE_MAX    = SIDE_MAX_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [IDX_W-1:0]     in_row,
  input  logic [IDX_W-1:0]     in_col,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [IDX_W-1:0]     out_row,
  output logic [IDX_W-1:0]     out_col,
  output logic [ITER_W-1:0]    out_iteration_count,
  output logic                 out_escaped,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  met_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  met_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  met_dp #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS),
    .SIDE_MAX    (SIDE_MAX)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_row              (in_row),
    .in_col              (in_col),
    .cfg                 (cfg),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_row             (out_row),
    .out_col             (out_col),
    .out_iteration_count (out_iteration_count),
    .out_escaped         (out_escaped)
  );

endmodule
